// File: src/smoothstep_easing_interpolator_unit_assert.svh
// Assertion macros for the smoothstep easing interpolator checker
`ifndef SMOOTHSTEP_EASING_INTERPOLATOR_UNIT_ASSERT_SVH
`define SMOOTHSTEP_EASING_INTERPOLATOR_UNIT_ASSERT_SVH

`define SEI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define SEI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sei_pkg.sv
// Shared constants and types for the smoothstep easing interpolator
package sei_pkg;

    localparam int NST     = 14;
    localparam int QW      = 9;
    localparam int DIV_ST  = 9;
    localparam int DIV_LO  = 1;

    localparam logic [15:0]        DUR_MAX = 16'd60000;
    localparam logic [15:0]        DUR_MIN = 16'd1;
    localparam logic signed [20:0] END_MAX = 21'sd1000000;
    localparam logic signed [20:0] END_MIN = -21'sd1000000;
    localparam logic [9:0]         CURVE_K = 10'd768;

    typedef struct packed {
        logic signed [20:0] a;
        logic signed [20:0] b;
    } t_tag;

endpackage

// File: src/sei_div.sv
// Pipelined restoring divider: quotient of elapsed*256 by duration, one bit per stage
module sei_div (
    input  logic                 i_clk,
    input  logic [sei_pkg::DIV_ST-1:0] i_adv,
    input  logic [15:0]          i_el,
    input  logic [15:0]          i_dur,
    input  sei_pkg::t_tag        i_tag,
    output logic [sei_pkg::QW-1:0] o_q,
    output sei_pkg::t_tag        o_tag
);
    import sei_pkg::*;

    logic [15:0]   r_rem [DIV_ST];
    logic [15:0]   r_dur [DIV_ST];
    logic [QW-1:0] r_q   [DIV_ST];
    t_tag          r_tag [DIV_ST];

    genvar k;
    generate
        for (k = 0; k < DIV_ST; k++) begin : g_st
            logic [16:0]   x;
            logic [15:0]   d;
            logic [QW-1:0] qp;
            logic          ge;
            logic [QW-1:0] n_q;
            logic [16:0]   n_rem;
            t_tag          tg;

            if (k == 0) begin : g_first
                assign x  = {1'b0, i_el};
                assign d  = i_dur;
                assign qp = '0;
                assign tg = i_tag;
            end else begin : g_next
                assign x  = {r_rem[k-1], 1'b0};
                assign d  = r_dur[k-1];
                assign qp = r_q[k-1];
                assign tg = r_tag[k-1];
            end

            always_comb begin
                ge = (x >= {1'b0, d});
                n_rem = ge ? (x - {1'b0, d}) : x;
                n_q = qp;
                n_q[QW-1-k] = ge;
            end

            always_ff @(posedge i_clk) begin
                if (i_adv[k]) begin
                    r_rem[k] <= n_rem[15:0];
                    r_dur[k] <= d;
                    r_q[k]   <= n_q;
                    r_tag[k] <= tg;
                end
            end
        end
    endgenerate

    assign o_q   = r_q[DIV_ST-1];
    assign o_tag = r_tag[DIV_ST-1];

endmodule

// File: src/smoothstep_easing_interpolator_unit.sv
// Top level of the smoothstep easing interpolator
//
//  channel   dir  fields (tdata, low bit up)
//  s_axis    in   elapsed_time[16:0] total_duration[32:17] from_value[53:33] to_value[74:54]
//  m_axis    out  eased_value[20:0]
//
// Stages: clamp, nine divider bit stages, square, curve, scale, round.
// One request per cycle unless stalled; the nine-stage restoring divider sets the depth.
// Reset clears all stage valid bits; data registers are not reset.
// A stall stops only the stages behind a full one, so bubbles still close up.
module smoothstep_easing_interpolator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,  // elapsed_time, total_duration, from_value, to_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // eased_value, zero pad
);
    import sei_pkg::*;

    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;

    logic signed [16:0] in_el;
    logic [15:0]        in_dur;
    logic signed [20:0] in_a;
    logic signed [20:0] in_b;
    logic [15:0]        n_dur;
    logic [15:0]        n_el;
    t_tag               n_tag;

    logic [15:0] r_el0;
    logic [15:0] r_dur0;
    t_tag        r_tag0;

    logic [QW-1:0] div_q;
    t_tag          div_tag;

    logic [17:0]        r_t2;
    logic [9:0]         r_w;
    logic signed [21:0] r_span1;
    logic signed [20:0] r_a1;
    logic [24:0]        curve;
    logic [8:0]         r_e;
    logic signed [21:0] r_span2;
    logic signed [20:0] r_a2;
    logic signed [31:0] r_prod;
    logic signed [20:0] r_a3;
    logic signed [31:0] rnd;
    logic signed [31:0] res;
    logic [20:0]        r_res;

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_m_axis_tready;
        for (int i = NST-2; i >= 0; i--) begin
            adv[i] = !r_v[i] || adv[i+1];
        end
    end

    assign o_s_axis_tready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_comb begin
        in_el  = i_s_axis_tdata[16:0];
        in_dur = i_s_axis_tdata[32:17];
        in_a   = i_s_axis_tdata[53:33];
        in_b   = i_s_axis_tdata[74:54];
        if (in_dur < DUR_MIN) begin
            n_dur = DUR_MIN;
        end else if (in_dur > DUR_MAX) begin
            n_dur = DUR_MAX;
        end else begin
            n_dur = in_dur;
        end
        if (in_el[16]) begin
            n_el = '0;
        end else if (in_el[15:0] > n_dur) begin
            n_el = n_dur;
        end else begin
            n_el = in_el[15:0];
        end
        n_tag.a = (in_a > END_MAX) ? END_MAX : ((in_a < END_MIN) ? END_MIN : in_a);
        n_tag.b = (in_b > END_MAX) ? END_MAX : ((in_b < END_MIN) ? END_MIN : in_b);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_el0  <= n_el;
            r_dur0 <= n_dur;
            r_tag0 <= n_tag;
        end
    end

    sei_div u_div (
        .i_clk (i_clk),
        .i_adv (adv[DIV_ST:DIV_LO]),
        .i_el  (r_el0),
        .i_dur (r_dur0),
        .i_tag (r_tag0),
        .o_q   (div_q),
        .o_tag (div_tag)
    );

    always_ff @(posedge i_clk) begin
        if (adv[10]) begin
            r_t2    <= 18'(div_q) * 18'(div_q);
            r_w     <= CURVE_K - {div_q, 1'b0};
            r_span1 <= 22'(div_tag.b) - 22'(div_tag.a);
            r_a1    <= div_tag.a;
        end
    end

    assign curve = {8'd0, r_t2[16:0]} * {15'd0, r_w};

    always_ff @(posedge i_clk) begin
        if (adv[11]) begin
            r_e     <= curve[24:16];
            r_span2 <= r_span1;
            r_a2    <= r_a1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[12]) begin
            r_prod <= 32'(r_span2) * $signed({23'd0, r_e});
            r_a3   <= r_a2;
        end
    end

    always_comb begin
        rnd = r_prod + (r_prod[31] ? 32'sd255 : 32'sd0);
        res = 32'(r_a3) + (rnd >>> 8);
    end

    always_ff @(posedge i_clk) begin
        if (adv[13]) begin
            r_res <= res[20:0];
        end
    end

    assign o_m_axis_tvalid = r_v[NST-1];
    assign o_m_axis_tdata  = {3'd0, r_res};

endmodule

// File: src/sei_chk.sv
// Port checker for the smoothstep easing interpolator, bound to the top level
`include "smoothstep_easing_interpolator_unit_assert.svh"

module sei_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);
    `SEI_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "valid after reset")
    `SEI_ASSERT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result dropped")
    `SEI_ASSERT(a_pad, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tdata[23:21] == 3'd0, "pad bits set")
    `SEI_ASSERT(a_range, i_clk, i_rst_n, o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[20:0]) <= 21'sd1000000 && $signed(o_m_axis_tdata[20:0]) >= -21'sd1000000), "result out of range")
endmodule

bind smoothstep_easing_interpolator_unit sei_chk u_sei_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: sim/tb_top.sv
// Self-checking testbench for the smoothstep easing interpolator unit
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic signed [20:0] to_value;
        logic signed [20:0] from_value;
        logic [15:0]        total_duration;
        logic signed [16:0] elapsed_time;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata;   // elapsed_time, total_duration, from_value, to_value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // eased_value, zero pad

    t_request           pending_requests[$];
    logic signed [20:0] expected_values[$];
    int                 error_count;
    bit                 stimulus_done;
    int                 burst_left;
    int                 gap_left;
    int                 stall_phase;
    int                 stall_mode;

    smoothstep_easing_interpolator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic signed [20:0] ease_value(t_request r);
        longint el;
        longint dur;
        longint a;
        longint b;
        longint t;
        longint e;
        longint res;
        dur = r.total_duration;
        if (dur < 1) dur = 1;
        if (dur > 60000) dur = 60000;
        el = r.elapsed_time;
        if (el < 0) el = 0;
        if (el > dur) el = dur;
        a = r.from_value;
        b = r.to_value;
        if (a < -1000000) a = -1000000;
        if (a > 1000000) a = 1000000;
        if (b < -1000000) b = -1000000;
        if (b > 1000000) b = 1000000;
        t = (el * 256) / dur;
        e = (t * t * (768 - 2 * t)) / 65536;
        res = a + ((b - a) * e) / 256;
        return res[20:0];
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       k;
        r.elapsed_time   = 17'($urandom);
        r.total_duration = 16'($urandom);
        r.from_value     = 21'($urandom);
        r.to_value       = 21'($urandom);
        k = $urandom_range(0, 9);
        if (k < 4) begin
            r.total_duration = 16'($urandom_range(0, 1000));
            r.elapsed_time   = 17'($urandom_range(0, r.total_duration + 2));
        end else if (k < 7) begin
            r.elapsed_time = 17'($urandom_range(0, r.total_duration));
        end
        if ($urandom_range(0, 3) != 0) begin
            r.from_value = 21'($signed($urandom_range(0, 2000000)) - 1000000);
            r.to_value   = 21'($signed($urandom_range(0, 2000000)) - 1000000);
        end
        return r;
    endfunction

    function automatic t_request make_request(int el, int dur, int a, int b);
        t_request r;
        r.elapsed_time   = 17'(el);
        r.total_duration = 16'(dur);
        r.from_value     = 21'(a);
        r.to_value       = 21'(b);
        return r;
    endfunction

    initial begin
        pending_requests.push_back(make_request(0, 100, -1000000, 1000000));
        pending_requests.push_back(make_request(100, 100, -1000000, 1000000));
        pending_requests.push_back(make_request(50, 100, 1000000, -1000000));
        pending_requests.push_back(make_request(0, 0, 5, 9));
        pending_requests.push_back(make_request(1, 0, 5, 9));
        pending_requests.push_back(make_request(60000, 65535, 0, 1000000));
        pending_requests.push_back(make_request(30000, 65535, 0, 1000000));
        pending_requests.push_back(make_request(65535, 65535, -7, 7));
        pending_requests.push_back(make_request(-65536, 1000, 3, -3));
        pending_requests.push_back(make_request(-1, 1000, 123, 456));
        pending_requests.push_back(make_request(2000, 1000, 123, 456));
        pending_requests.push_back(make_request(500, 1000, -1048576, 1048575));
        pending_requests.push_back(make_request(500, 1000, 1048575, -1048576));
        pending_requests.push_back(make_request(1, 60000, -1000000, 1000000));
        pending_requests.push_back(make_request(59999, 60000, -1000000, 1000000));
        pending_requests.push_back(make_request(333, 1000, -1, 1));
        pending_requests.push_back(make_request(777, 1000, 999999, -999999));
        pending_requests.push_back(make_request(1, 3, 0, 1000000));
        pending_requests.push_back(make_request(2, 3, -1000000, 0));
        pending_requests.push_back(make_request(65535, 0, 0, 0));
        for (int i = 0; i < 1900; i++) begin
            pending_requests.push_back(random_request());
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        error_count     = 0;
        stimulus_done   = 1'b0;
        burst_left      = 0;
        gap_left        = 0;
        stall_phase     = 0;
        stall_mode      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_values.push_back(ease_value(t_request'(i_s_axis_tdata[74:0])));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {5'd0, pending_requests.pop_front()};
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                    stimulus_done   <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_values.size() == 0) begin
                    $error("eased_value: unexpected result %0d",
                           $signed(o_m_axis_tdata[20:0]));
                    error_count++;
                end else begin
                    if (o_m_axis_tdata[20:0] !== expected_values[0]) begin
                        $error("eased_value: expected %0d, actual %0d",
                               expected_values[0], $signed(o_m_axis_tdata[20:0]));
                        error_count++;
                    end
                    void'(expected_values.pop_front());
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= (stall_phase % 3) != 0;
                2: i_m_axis_tready <= 1'($urandom_range(0, 1));
                default: i_m_axis_tready <= (stall_phase % 16) < 5;
            endcase
        end
    end

    initial begin
        wait (i_rst_n);
        wait (stimulus_done && expected_values.size() == 0);
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_values.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
